// ===== hdl/rcr_pkg.sv =====
// ---------------------------------------------------------------------------
// rcr_pkg
// Types, constants and shade tables shared by the column renderer.
// ---------------------------------------------------------------------------
package rcr_pkg;

    localparam int POS_W  = 16;
    localparam int ANG_W  = 12;
    localparam int COL_W  = 8;
    localparam int DIR_W  = 16;
    localparam int FOV_W  = 11;
    localparam int STEP_W = 12;
    localparam int DIST_W = 17;
    localparam int CEIL_W = 5;
    localparam int FLR_W  = 6;
    localparam int GLY_W  = 8;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 64;

    localparam logic [IDX_W-1:0] REG_MAP0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAP1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAP2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAP3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_FOV  = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAXD = 3'd6;

    localparam logic [31:0] K1 = 32'd1686629713;
    localparam logic [31:0] K3 = 32'd693598668;
    localparam logic [31:0] K5 = 32'd85569306;
    localparam logic [31:0] K7 = 32'd5026995;
    localparam logic [31:0] K9 = 32'd172272;

    typedef struct packed {
        logic [255:0]        map;
        logic [FOV_W-1:0]    fov;
        logic [STEP_W-1:0]   step;
        logic [DIST_W-1:0]   maxd;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]        px;
        logic [POS_W-1:0]        py;
        logic signed [DIR_W-1:0] ex;
        logic signed [DIR_W-1:0] ey;
    } t_job;

    function automatic logic [GLY_W-1:0] wall_shade(input logic [3:0] idx);
        case (idx)
            4'd0:    wall_shade = 8'h24;
            4'd1:    wall_shade = 8'h40;
            4'd2:    wall_shade = 8'h25;
            4'd3:    wall_shade = 8'h4F;
            4'd4:    wall_shade = 8'h50;
            4'd5:    wall_shade = 8'h6F;
            4'd6:    wall_shade = 8'h63;
            4'd7:    wall_shade = 8'h3A;
            4'd8:    wall_shade = 8'h2E;
            default: wall_shade = 8'h20;
        endcase
    endfunction

    function automatic logic [GLY_W-1:0] floor_shade(input logic [1:0] idx);
        case (idx)
            2'd0:    floor_shade = 8'h27;
            2'd1:    floor_shade = 8'h2E;
            default: floor_shade = 8'h2D;
        endcase
    endfunction

endpackage

// ===== hdl/rcr_front.sv =====
// ---------------------------------------------------------------------------
// rcr_front
// Takes a column request, forms the ray angle and its sine and cosine.
// ---------------------------------------------------------------------------
module rcr_front #(
    parameter int VIEW_COLS = 160
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rcr_pkg::POS_W-1:0]   i_player_x,
    input  logic [rcr_pkg::POS_W-1:0]   i_player_y,
    input  logic [rcr_pkg::ANG_W-1:0]   i_heading,
    input  logic [rcr_pkg::COL_W-1:0]   i_column,
    input  logic [rcr_pkg::FOV_W-1:0]   i_fov,
    output logic                        o_push,
    input  logic                        i_full,
    output rcr_pkg::t_job               o_job
);
    import rcr_pkg::*;

    localparam int NUM_W  = COL_W + FOV_W;
    localparam int SHR    = NUM_W + $clog2(VIEW_COLS);
    localparam int RCP_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + RCP_W + ANG_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHR) + 64'(VIEW_COLS) - 64'd1) / 64'(VIEW_COLS);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIV  = 4'b0010,
        F_SIN  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate             r_state;
    logic [NUM_W-1:0]    r_num;
    logic [3:0]          r_sc;
    logic                r_which;
    logic [ANG_W-1:0]    r_head;
    logic [ANG_W-1:0]    r_ang;
    logic [30:0]         r_t2;
    logic [31:0]         r_p;
    logic [63:0]         r_prod;
    t_job                r_job;

    logic [PROD_W-1:0]   quo_prod;
    logic [ANG_W-1:0]    sin_ang;
    logic [10:0]         sin_i;
    logic [31:0]         mul_a, mul_b;
    logic [31:0]         kc;
    logic [63:0]         rnd;
    logic [15:0]         mag;
    logic signed [DIR_W-1:0] sval;

    assign quo_prod = PROD_W'(r_num) * PROD_W'(RECIP);
    assign sin_ang = r_which ? (r_ang + 12'd1024) : r_ang;
    assign sin_i   = sin_ang[10] ? (11'd1024 - {1'b0, sin_ang[9:0]}) : {1'b0, sin_ang[9:0]};
    assign mul_a   = (r_sc == 4'd0 || r_sc == 4'd10) ? {21'd0, sin_i} : {1'b0, r_t2};
    assign mul_b   = (r_sc == 4'd0) ? {21'd0, sin_i} : r_p;

    always_comb begin
        case (r_sc)
            4'd3:    kc = K7;
            4'd5:    kc = K5;
            4'd7:    kc = K3;
            default: kc = K1;
        endcase
    end

    assign rnd  = r_prod + 64'd33554432;
    assign mag  = (rnd[41:26] > 16'd16384) ? 16'd16384 : rnd[41:26];
    assign sval = sin_ang[11] ? -$signed(mag) : $signed(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_job.px <= i_player_x;
                        r_job.py <= i_player_y;
                        r_head   <= i_heading - ANG_W'(i_fov[FOV_W-1:1]);
                        r_num    <= NUM_W'(i_column) * NUM_W'(i_fov);
                        r_state  <= F_DIV;
                    end
                end
                F_DIV: begin
                    // divide by the screen width as a reciprocal multiply
                    r_ang   <= r_head + quo_prod[SHR +: ANG_W];
                    r_sc    <= '0;
                    r_which <= 1'b0;
                    r_state <= F_SIN;
                end
                F_SIN: begin
                    r_sc <= r_sc + 4'd1;
                    case (r_sc) inside
                        4'd1: begin
                            r_t2 <= {r_prod[20:0], 10'd0};
                            r_p  <= K9;
                        end
                        4'd3, 4'd5, 4'd7, 4'd9: r_p <= kc - r_prod[61:30];
                        4'd11: begin
                            r_sc <= '0;
                            if (r_which) begin
                                r_job.ey <= sval;
                                r_state  <= F_PUSH;
                            end else begin
                                r_job.ex <= sval;
                                r_which  <= 1'b1;
                            end
                        end
                        default: r_prod <= mul_a * mul_b;
                    endcase
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_job   = r_job;

    sin_cap_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_SIN && r_sc == 4'd11) |-> (mag <= 16'd16384))
        else $error("sine magnitude above one");
    sin_seq_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_SIN) |-> (r_sc <= 4'd11))
        else $error("sine step counter overran");
    push_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_state == F_IDLE))
        else $error("front did not return to idle after push");
endmodule

// ===== hdl/rcr_fifo.sv =====
// ---------------------------------------------------------------------------
// rcr_fifo
// Two-entry queue of ray jobs between front and march engine.
// ---------------------------------------------------------------------------
module rcr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rcr_pkg::t_job o_job
);
    import rcr_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    cnt_a: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overran");
    push_a: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into full queue");
    pop_a: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("pop from empty queue");
endmodule

// ===== hdl/rcr_march.sv =====
// ---------------------------------------------------------------------------
// rcr_march
// Marches one ray a step per cycle, then divides out rows and shade levels.
// ---------------------------------------------------------------------------
module rcr_march #(
    parameter int VIEW_ROWS = 45,
    parameter int MAP_SIZE  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rcr_pkg::t_cfg                i_cfg,
    input  logic                         i_empty,
    input  rcr_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rcr_pkg::CEIL_W-1:0]   o_ceiling_row,
    output logic [rcr_pkg::FLR_W-1:0]    o_floor_row,
    output logic [rcr_pkg::GLY_W-1:0]    o_wall_glyph,
    output logic [rcr_pkg::GLY_W-1:0]    o_floor_glyph,
    output logic [rcr_pkg::DIST_W-1:0]   o_distance
);
    import rcr_pkg::*;

    localparam int Q_W = $clog2(VIEW_ROWS + 1);
    localparam int N_W = 28;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_INIT  = 5'b00010,
        B_MARCH = 5'b00100,
        B_DIV   = 5'b01000,
        B_OUT   = 5'b10000
    } t_bstate;

    t_bstate              r_state;
    t_job                 r_job;
    logic [STEP_W-1:0]    r_step;
    logic [17:0]          r_d;
    logic signed [35:0]   r_ax, r_ay, r_sx, r_sy;
    logic [N_W-1:0]       r_num, r_den;
    logic [Q_W-1:0]       r_q, r_cap, r_ceil;
    logic [1:0]           r_which;
    logic [3:0]           r_wi;
    logic [1:0]           r_fi;
    logic                 r_valid;

    logic signed [28:0]   mx, my;
    logic                 outside, wall, stop;
    logic [8:0]           cx, cy;
    logic [17:0]          dn;

    assign mx = r_job.ex * $signed({1'b0, r_step});
    assign my = r_job.ey * $signed({1'b0, r_step});
    assign cx = r_ax[34:26];
    assign cy = r_ay[34:26];
    assign outside = r_ax[35] || r_ay[35] || cx >= 9'(MAP_SIZE) || cy >= 9'(MAP_SIZE);
    assign wall    = i_cfg.map[{cy[3:0], cx[3:0]}];
    assign dn      = outside ? {1'b0, i_cfg.maxd} : r_d;
    assign stop    = outside || wall || (r_d > {1'b0, i_cfg.maxd});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_state == B_OUT && (!r_valid || i_ready)) r_valid <= 1'b1;
            else if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_step  <= (i_cfg.step == '0) ? STEP_W'(1) : i_cfg.step;
                        r_state <= B_INIT;
                    end
                end
                B_INIT: begin
                    r_sx    <= 36'(mx);
                    r_sy    <= 36'(my);
                    r_ax    <= $signed({6'd0, r_job.px, 14'd0}) + 36'(mx);
                    r_ay    <= $signed({6'd0, r_job.py, 14'd0}) + 36'(my);
                    r_d     <= 18'(r_step);
                    r_state <= B_MARCH;
                end
                B_MARCH: begin
                    if (stop) begin
                        r_d     <= dn;
                        // short distance: ceiling pinned to row 0
                        r_num   <= (dn <= 18'd8192) ? '0 :
                                   N_W'(dn - 18'd8192) * N_W'(VIEW_ROWS);
                        r_den   <= N_W'({dn, 1'b0});
                        r_cap   <= (dn <= 18'd8192) ? '0 : Q_W'(VIEW_ROWS);
                        r_q     <= '0;
                        r_which <= 2'd0;
                        r_state <= B_DIV;
                    end else begin
                        r_d  <= r_d + 18'(r_step);
                        r_ax <= r_ax + r_sx;
                        r_ay <= r_ay + r_sy;
                    end
                end
                B_DIV: begin
                    // repeated subtraction, capped at the clamp level
                    if (r_num >= r_den && r_q != r_cap) begin
                        r_num <= r_num - r_den;
                        r_q   <= r_q + Q_W'(1);
                    end else begin
                        r_q <= '0;
                        case (r_which)
                            2'd0: begin
                                r_ceil  <= r_q;
                                r_num   <= N_W'(r_d) * N_W'(10);
                                r_den   <= N_W'(i_cfg.maxd);
                                r_cap   <= Q_W'(9);
                                r_which <= 2'd1;
                            end
                            2'd1: begin
                                r_wi    <= r_q[3:0];
                                r_num   <= N_W'(r_d) * N_W'(3);
                                r_cap   <= Q_W'(2);
                                r_which <= 2'd2;
                            end
                            default: begin
                                r_fi    <= r_q[1:0];
                                r_state <= B_OUT;
                            end
                        endcase
                    end
                end
                B_OUT: begin
                    if (!r_valid || i_ready) begin
                        o_ceiling_row <= r_ceil[CEIL_W-1:0];
                        o_floor_row   <= FLR_W'(10'(VIEW_ROWS) - 10'(r_ceil));
                        o_wall_glyph  <= wall_shade(r_wi);
                        o_floor_glyph <= floor_shade(r_fi);
                        o_distance    <= r_d[17] ? {DIST_W{1'b1}} : r_d[DIST_W-1:0];
                        r_state       <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = r_valid;

    march_d_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MARCH) |-> (r_d != '0))
        else $error("march with zero distance");
    div_cap_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_q <= r_cap))
        else $error("quotient passed its clamp");
    out_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT && (!r_valid || i_ready)) |=> (r_valid && r_state == B_IDLE))
        else $error("result not issued");
endmodule

// ===== hdl/raycast_column_renderer.sv =====
// ---------------------------------------------------------------------------
// raycast_column_renderer
// Grid ray caster column: angle and sine front, queued march back end.
// ---------------------------------------------------------------------------
// Path: the front forms the angle, works out the sine and the cosine and
// queues the job; the march engine starts the ray, takes up to
// max_distance/step_size + 1 march steps, divides out the row and shade
// levels, and registers the result.
// Throughput: one column at a time per stage, set by the march loop.
// Reset: synchronous active low; registers take their defaults, queue empties.
module raycast_column_renderer #(
    parameter int VIEW_COLS = 160,
    parameter int VIEW_ROWS = 45,
    parameter int MAP_SIZE  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rcr_pkg::POS_W-1:0]    i_player_x,
    input  logic [rcr_pkg::POS_W-1:0]    i_player_y,
    input  logic [rcr_pkg::ANG_W-1:0]    i_heading,
    input  logic [rcr_pkg::COL_W-1:0]    i_column,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rcr_pkg::CEIL_W-1:0]   o_ceiling_row,
    output logic [rcr_pkg::FLR_W-1:0]    o_floor_row,
    output logic [rcr_pkg::GLY_W-1:0]    o_wall_glyph,
    output logic [rcr_pkg::GLY_W-1:0]    o_floor_glyph,
    output logic [rcr_pkg::DIST_W-1:0]   o_distance,
    input  logic                         i_cfg_we,
    input  logic [rcr_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [rcr_pkg::CFG_W-1:0]    i_cfg_data
);
    import rcr_pkg::*;

    logic [63:0]        r_map [4];
    logic [FOV_W-1:0]   r_fov;
    logic [STEP_W-1:0]  r_step;
    logic [DIST_W-1:0]  r_maxd;
    t_cfg               cfg;
    t_job               f_job, q_job;
    logic               push, full, pop, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map[0] <= '0;
            r_map[1] <= '0;
            r_map[2] <= '0;
            r_map[3] <= '0;
            r_fov    <= FOV_W'(512);
            r_step   <= STEP_W'(123);
            r_maxd   <= DIST_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAP0: r_map[0] <= i_cfg_data;
                REG_MAP1: r_map[1] <= i_cfg_data;
                REG_MAP2: r_map[2] <= i_cfg_data;
                REG_MAP3: r_map[3] <= i_cfg_data;
                REG_FOV:  r_fov    <= i_cfg_data[FOV_W-1:0];
                REG_STEP: r_step   <= i_cfg_data[STEP_W-1:0];
                REG_MAXD: r_maxd   <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.map  = {r_map[3], r_map[2], r_map[1], r_map[0]};
    assign cfg.fov  = r_fov;
    assign cfg.step = r_step;
    assign cfg.maxd = r_maxd;

    rcr_front #(.VIEW_COLS(VIEW_COLS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_player_x(i_player_x), .i_player_y(i_player_y),
        .i_heading(i_heading), .i_column(i_column),
        .i_fov(r_fov), .o_push(push), .i_full(full), .o_job(f_job)
    );

    rcr_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_job(f_job), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_job(q_job)
    );

    rcr_march #(.VIEW_ROWS(VIEW_ROWS), .MAP_SIZE(MAP_SIZE)) u_march (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg),
        .i_empty(empty), .i_job(q_job), .o_pop(pop),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_ceiling_row(o_ceiling_row), .o_floor_row(o_floor_row),
        .o_wall_glyph(o_wall_glyph), .o_floor_glyph(o_floor_glyph),
        .o_distance(o_distance)
    );
endmodule
